### rtl/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Request from the controller to the compression core.
  typedef struct packed {
    logic start;
    logic init_hash;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[r];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

### rtl/sha_core.sv
// SHA-256 compression core: message window held as registers, hash words in a memory with registered read.
module sha_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sha_pkg::core_req_t  req,
  // load port: block words written before start
  input  logic                ld_we,
  input  logic [3:0]          ld_addr,
  input  logic [31:0]         ld_data,
  // hash read port for digest output
  input  logic [2:0]          hrd_addr,
  output logic [31:0]         hrd_data,
  output sha_pkg::core_sts_t  sts
);

  typedef enum logic [5:0] {
    C_IDLE  = 6'b000001,
    C_HLOAD = 6'b000010,
    C_ROUND = 6'b000100,
    C_WAIT  = 6'b001000,
    C_ADD   = 6'b010000,
    C_INIT  = 6'b100000
  } cstate_t;

  // message schedule window, 16 words
  logic [31:0] wmem [16];
  // hash words
  logic [31:0] hmem [8];

  cstate_t     state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] va [8];

  // Window is read at four addresses per round; it is small enough to keep
  // as registers with one write per cycle.
  logic [5:0]  r;
  logic [31:0] w_t, w2, w7, w15, w16, s0, s1, t1, t2, e0, e1, ch, mj;
  logic        w_we;
  logic [3:0]  w_wa;
  logic [31:0] w_wd;
  logic        h_we;
  logic [2:0]  h_wa, h_ra;
  logic [31:0] h_wd, h_rd_r;

  assign r   = cnt_r[5:0];
  assign w2  = wmem[4'(r - 6'd2)];
  assign w7  = wmem[4'(r - 6'd7)];
  assign w15 = wmem[4'(r - 6'd15)];
  assign w16 = wmem[r[3:0]];
  assign s1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
  assign s0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
  assign w_t = (r < 6'd16) ? w16 : (s1 + w7 + s0 + w16);
  assign e1  = sha_pkg::rotr(e_r, 6) ^ sha_pkg::rotr(e_r, 11) ^ sha_pkg::rotr(e_r, 25);
  assign ch  = (e_r & f_r) ^ (~e_r & g_r);
  assign t1  = h_r + e1 + ch + sha_pkg::round_k(r) + w_t;
  assign e0  = sha_pkg::rotr(a_r, 2) ^ sha_pkg::rotr(a_r, 13) ^ sha_pkg::rotr(a_r, 22);
  assign mj  = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
  assign t2  = e0 + mj;

  assign va = '{a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r};

  always_comb begin
    w_we = 1'b0;
    w_wa = ld_addr;
    w_wd = ld_data;
    if (state_r == C_IDLE && ld_we) begin
      w_we = 1'b1;
    end else if (state_r == C_ROUND && r >= 6'd16) begin
      w_we = 1'b1;
      w_wa = r[3:0];
      w_wd = w_t;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_wa] <= w_wd;
    end
  end

  // Hash memory: one read, one write per cycle, registered read.
  always_comb begin
    h_we = 1'b0;
    h_wa = cnt_r[2:0];
    h_wd = h_rd_r + va[cnt_r[2:0]];
    h_ra = hrd_addr;
    case (state_r)
      C_HLOAD: h_ra = cnt_r[2:0];
      C_ADD: begin
        h_ra = 3'(cnt_r[2:0] + 3'd1);
        h_we = 1'b1;
      end
      C_INIT: begin
        h_we = 1'b1;
        h_wd = sha_pkg::init_h(cnt_r[2:0]);
      end
      C_WAIT:  h_ra = 3'd0;
      default: h_ra = hrd_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    h_rd_r <= hmem[h_ra];
  end

  assign hrd_data = h_rd_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      C_IDLE: begin
        cnt_nxt = '0;
        if (req.init_hash) begin
          state_nxt = C_INIT;
        end else if (req.start) begin
          state_nxt = C_HLOAD;
        end
      end
      C_HLOAD: begin
        // hash read is registered: count 0..8
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd8) begin
          state_nxt = C_ROUND;
          cnt_nxt   = '0;
        end
      end
      C_ROUND: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          state_nxt = C_WAIT;
          cnt_nxt   = '0;
        end
      end
      C_WAIT: state_nxt = C_ADD;
      C_ADD: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd7) begin
          state_nxt = C_IDLE;
        end
      end
      C_INIT: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd7) begin
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working variables: load serially from hash memory, then rotate per round.
  always_ff @(posedge clk) begin
    if (state_r == C_HLOAD && cnt_r != 7'd0) begin
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <=
        {b_r, c_r, d_r, e_r, f_r, g_r, h_r, h_rd_r};
    end else if (state_r == C_ROUND) begin
      h_r <= g_r;
      g_r <= f_r;
      f_r <= e_r;
      e_r <= d_r + t1;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= a_r;
      a_r <= t1 + t2;
    end
  end

  assign sts.busy = (state_r != C_IDLE);
  assign sts.done = (state_r == C_ADD && cnt_r == 7'd7) ||
                    (state_r == C_INIT && cnt_r == 7'd7);

  a_round_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_ROUND && cnt_r == 7'd63 |=> state_r == C_WAIT)
    else $error("round phase length broken");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ld_we |-> state_r == C_IDLE)
    else $error("block load while core busy");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == C_IDLE)
    else $error("start while busy");

endmodule

### rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte packing, padding and digest output.
//
// Usage: feed message bytes one per word on the in_ channel (in_valid/in_ready,
// payload in_data of sha_pkg::in_word_t). Set has_byte with a byte; set
// end_of_message on the final word, with or without a byte. After the final
// word the block pads the message, compresses one or two last blocks and sends
// the eight digest words on the out_ channel, word 0 first, last_word on word 7.
// Bytes are packed into 32-bit words; each fourth byte costs one word write into
// the core's schedule memory. A full 64-byte block stops input while it is
// compressed: launch, hash load, 64 rounds, hash add-back, then resume. Bytes
// go in at one per cycle while in_ready is high. End of message adds the padding
// writes and one or two compressions before the first digest word; each word
// then takes a hash read and a load of the output register. A stalled receiver
// holds the current digest word in the output register; no input is taken until
// all eight have gone, then the hash is reloaded and in_ready rises again once
// the reload is done. After reset the core writes the initial hash values, and
// in_ready rises once the core is idle and the top level has left its wait state.
module sha256_stream_hasher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_word_t out_data
);

  typedef enum logic [7:0] {
    S_ABSORB = 8'b00000001,
    S_COMP   = 8'b00000010,
    S_PADW   = 8'b00000100,
    S_PADC   = 8'b00001000,
    S_RDH    = 8'b00010000,
    S_OUT    = 8'b00100000,
    S_REINIT = 8'b01000000,
    S_WAIT   = 8'b10000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [63:0]        count_r, count_nxt;
  logic [23:0]        pack_r, pack_nxt;   // earlier bytes of the current word
  logic               eom_r, eom_nxt;     // padding pending after compression
  logic               pad2_r, pad2_nxt;   // block being padded is the length-only block
  logic [3:0]         pw_r, pw_nxt;       // padding word address
  logic [2:0]         oidx_r, oidx_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [31:0]        oword_r;
  logic [2:0]         oindex_r;
  logic               olast_r;
  sha_pkg::core_req_t req;
  sha_pkg::core_sts_t sts;
  logic               ld_we;
  logic [3:0]         ld_addr;
  logic [31:0]        ld_data;
  logic [31:0]        hrd_data;
  logic               accept;
  logic [5:0]         fill;
  logic [63:0]        bits;
  logic [31:0]        pad_word;

  sha_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .ld_we    (ld_we),
    .ld_addr  (ld_addr),
    .ld_data  (ld_data),
    .hrd_addr (oidx_r),
    .hrd_data (hrd_data),
    .sts      (sts)
  );

  assign in_ready = (state_r == S_ABSORB) && !sts.busy;
  assign accept   = in_valid && in_ready;
  assign fill     = count_r[5:0];
  assign bits     = {count_r[60:0], 3'b000};

  // Padding word at pw_r: bytes before fill keep packed data (partial word),
  // byte fill gets 0x80 when this block carries it, length in words 14 and 15
  // of the final block.
  always_comb begin
    logic [31:0] wv;
    logic [31:0] part;
    logic [7:0]  bv;
    logic [5:0]  bi;
    wv = '0;
    // left-align the bytes already held for the partial word
    case (fill[1:0])
      2'd1:    part = {pack_r[7:0], 24'h000000};
      2'd2:    part = {pack_r[15:0], 16'h0000};
      default: part = {pack_r, 8'h00};
    endcase
    for (int j = 0; j < 4; j++) begin
      bi = {pw_r, 2'(j)};
      bv = 8'h00;
      if (!pad2_r && bi < fill) begin
        bv = part[31 - 8*j -: 8];
      end else if (!pad2_r && bi == fill) begin
        bv = sha_pkg::PAD_BYTE;
      end
      wv[31 - 8*j -: 8] = bv;
    end
    if (!(!pad2_r && fill >= 6'd56)) begin
      if (pw_r == 4'd14) begin
        wv = bits[63:32];
      end else if (pw_r == 4'd15) begin
        wv = bits[31:0];
      end
    end
    pad_word = wv;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pack_nxt   = pack_r;
    eom_nxt    = eom_r;
    pad2_nxt   = pad2_r;
    pw_nxt     = pw_r;
    oidx_nxt   = oidx_r;
    ovalid_nxt = ovalid_r;
    req        = '0;
    ld_we      = 1'b0;
    ld_addr    = count_r[5:2];
    ld_data    = {pack_r, in_data.data_byte};
    case (state_r)
      S_ABSORB: begin
        if (accept) begin
          eom_nxt  = in_data.end_of_message;
          pad2_nxt = 1'b0;
          if (in_data.has_byte) begin
            count_nxt = count_r + 64'd1;
            pack_nxt  = {pack_r[15:0], in_data.data_byte};
            if (count_r[1:0] == 2'd3) begin
              ld_we = 1'b1;
            end
          end
          if (in_data.has_byte && count_r[5:0] == 6'd63) begin
            state_nxt = S_COMP;
          end else if (in_data.end_of_message) begin
            state_nxt = S_PADW;
            pw_nxt    = in_data.has_byte ? 4'(count_nxt[5:2]) : count_r[5:2];
          end
        end
      end
      S_COMP: begin
        // launch compression of a full block, then pad or resume
        req.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!sts.busy) begin
          if (pad2_r && !eom_r) begin
            // final block compressed: read out the digest
            state_nxt = S_RDH;
            oidx_nxt  = '0;
          end else if (eom_r) begin
            state_nxt = S_PADW;
            pw_nxt    = pad2_r ? 4'd0 : fill[5:2];
          end else begin
            state_nxt = S_ABSORB;
          end
        end
      end
      S_PADW: begin
        ld_we   = 1'b1;
        ld_addr = pw_r;
        ld_data = pad_word;
        pw_nxt  = pw_r + 4'd1;
        if (pw_r == 4'd15) begin
          state_nxt = S_PADC;
        end
      end
      S_PADC: begin
        req.start = 1'b1;
        state_nxt = S_WAIT;
        pad2_nxt  = 1'b1;
        // drop the pending flag once the block with the length is launched;
        // otherwise a length-only block follows
        if (pad2_r || fill < 6'd56) begin
          eom_nxt = 1'b0;
        end
      end
      S_RDH: begin
        // hash memory read for word oidx_r lands next cycle
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        ovalid_nxt = 1'b1;
        state_nxt  = S_RDH;
        oidx_nxt   = oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          state_nxt = S_REINIT;
        end
      end
      S_REINIT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b0;
          req.init_hash = 1'b1;
          count_nxt  = '0;
          eom_nxt    = 1'b0;
          pad2_nxt   = 1'b0;
          state_nxt  = S_WAIT;
        end
      end
      default: state_nxt = S_ABSORB;
    endcase
    if (ovalid_r && out_ready && state_r != S_RDH && state_r != S_REINIT) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_WAIT;
      count_r  <= '0;
      eom_r    <= 1'b0;
      pad2_r   <= 1'b0;
      pw_r     <= '0;
      oidx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      eom_r    <= eom_nxt;
      pad2_r   <= pad2_nxt;
      pw_r     <= pw_nxt;
      oidx_r   <= oidx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Hold the digest word; capture when the hash read lands.
  always_ff @(posedge clk) begin
    pack_r <= pack_nxt;
    if (state_r == S_OUT) begin
      oword_r  <= hrd_data;
      oindex_r <= oidx_r;
      olast_r  <= (oidx_r == 3'd7);
    end
  end

  assign out_data  = '{digest_word: oword_r, word_index: oindex_r, last_word: olast_r};
  assign out_valid = ovalid_r;

  a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !ovalid_r)
    else $error("input taken during digest output");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_word |-> out_data.word_index == 3'd7)
    else $error("last word flag on wrong index");
  a_pad_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PADW |-> !sts.busy)
    else $error("padding write while core busy");

endmodule
